// ----- hdl/sws_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Seven-segment writer package
// Shared constants and types for the two-wire seven-segment display writer.
// -----------------------------------------------------------------------------
package sws_pkg;

   localparam int MaxDigits     = 4;
   localparam int DigitsDefault = 4;
   localparam int SegW          = 8;
   localparam int BrightW       = 3;

   localparam logic [SegW-1:0]    CmdData      = 8'h40;
   localparam logic [SegW-1:0]    CmdAddr      = 8'hC0;
   localparam logic [SegW-1:0]    CmdDisplay   = 8'h88;
   localparam logic [BrightW-1:0] BrightReset  = 3'd7;

   // Frame codes in transmission order.
   localparam logic [1:0] FrameData = 2'd0;
   localparam logic [1:0] FrameAddr = 2'd1;
   localparam logic [1:0] FrameCtrl = 2'd2;

   typedef logic [MaxDigits-1:0][SegW-1:0] seg_vec_type;

   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic busy_res;
      logic done_res;
   } seq_out_type;

endpackage

// ----- hdl/sws_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Seven-segment writer channels
// Valid/ready channel interfaces for request beats and response beats.
// -----------------------------------------------------------------------------
interface sws_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] segment_0;
   logic [7:0] segment_1;
   logic [7:0] segment_2;
   logic [7:0] segment_3;

   modport source (output valid, mode, segment_0, segment_1, segment_2, segment_3,
                   input ready);
   modport sink   (input valid, mode, segment_0, segment_1, segment_2, segment_3,
                   output ready);
endinterface

interface sws_rsp_if;
   logic valid;
   logic ready;
   logic clock_line;
   logic data_line;
   logic busy_res;
   logic done_res;

   modport source (output valid, clock_line, data_line, busy_res, done_res,
                   input ready);
   modport sink   (input valid, clock_line, data_line, busy_res, done_res,
                   output ready);
endinterface

// ----- hdl/sws_seq.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Seven-segment writer sequencer
// Steps through start, bit, acknowledge and stop writes, one pin write a tick.
// -----------------------------------------------------------------------------
module sws_seq
   import sws_pkg::*;
#(
   parameter int DIGITS = DigitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [BrightW-1:0]  csr_write_data,
   input  logic                accept,
   input  logic                mode,
   input  seg_vec_type         segments,
   output seq_out_type         result
);

   localparam int ByteW   = $clog2(DIGITS + 2);
   localparam int SegIdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // Sub-step positions inside each state.
   localparam logic [2:0] EdgeFirst  = 3'd0;
   localparam logic [2:0] EdgeSecond = 3'd1;
   localparam logic [2:0] EdgeThird  = 3'd2;
   localparam logic [2:0] EdgeLast   = 3'd3;
   localparam logic [2:0] BitClkLow  = 3'd0;
   localparam logic [2:0] BitData    = 3'd1;
   localparam logic [2:0] AckClkLow  = 3'd0;
   localparam logic [2:0] AckRelease = 3'd1;
   localparam logic [2:0] AckClkHigh = 3'd2;
   localparam logic [2:0] AckClkDrop = 3'd3;
   localparam logic [2:0] BitLast    = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_BITS,
      ST_ACK,
      ST_STOP
   } state_type;

   state_type           state_ff,  state_in;
   logic [2:0]          sub_ff,    sub_in;
   logic [2:0]          bit_ff,    bit_in;
   logic [ByteW-1:0]    byte_ff,   byte_in;
   logic [1:0]          frame_ff,  frame_in;
   logic [SegW-1:0]     shift_ff,  shift_in;
   logic                clk_ff,    clk_in;
   logic                dat_ff,    dat_in;
   logic [BrightW-1:0]  bright_ff, bright_in;
   logic [SegW-1:0]     seg_ff [DIGITS];
   logic [SegW-1:0]     seg_in [DIGITS];
   logic                done_in;
   logic [SegW-1:0]     frame_byte;
   logic                last_byte;
   logic [ByteW-1:0]    seg_pos;

   assign seg_pos = byte_ff - ByteW'(1);

   always_comb begin
      case (frame_ff)
         FrameAddr: begin
            frame_byte = (byte_ff == '0) ? CmdAddr : seg_ff[seg_pos[SegIdxW-1:0]];
         end
         FrameCtrl: frame_byte = CmdDisplay | {{(SegW-BrightW){1'b0}}, bright_ff};
         default:   frame_byte = CmdData;
      endcase
   end

   assign last_byte = (frame_ff != FrameAddr) || (byte_ff == ByteW'(DIGITS));

   always_comb begin
      state_in  = state_ff;
      sub_in    = sub_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      frame_in  = frame_ff;
      shift_in  = shift_ff;
      clk_in    = clk_ff;
      dat_in    = dat_ff;
      bright_in = bright_ff;
      seg_in    = seg_ff;
      done_in   = 1'b0;

      if (csr_write_enable) begin
         bright_in = csr_write_data;
      end

      if (accept && mode) begin
         if (state_ff == ST_IDLE) begin
            for (int i = 0; i < DIGITS; i++) begin
               seg_in[i] = segments[i];
            end
            state_in = ST_START;
            sub_in   = EdgeFirst;
            bit_in   = '0;
            byte_in  = '0;
            frame_in = FrameData;
         end
      end else if (accept) begin
         unique case (state_ff)
            ST_IDLE: ;
            ST_START: begin
               unique case (sub_ff)
                  EdgeFirst:  dat_in = 1'b1;
                  EdgeSecond: clk_in = 1'b1;
                  EdgeThird:  dat_in = 1'b0;
                  default:    clk_in = 1'b0;
               endcase
               sub_in = sub_ff + 3'd1;
               if (sub_ff == EdgeLast) begin
                  state_in = ST_BITS;
                  sub_in   = BitClkLow;
                  bit_in   = '0;
               end
            end
            ST_BITS: begin
               sub_in = sub_ff + 3'd1;
               unique case (sub_ff)
                  BitClkLow: begin
                     if (bit_ff == '0) begin
                        shift_in = frame_byte;
                     end
                     clk_in = 1'b0;
                  end
                  BitData: begin
                     dat_in   = shift_ff[0];
                     shift_in = shift_ff >> 1;
                  end
                  default: begin
                     clk_in = 1'b1;
                     sub_in = BitClkLow;
                     bit_in = bit_ff + 3'd1;
                     if (bit_ff == BitLast) begin
                        state_in = ST_ACK;
                        sub_in   = AckClkLow;
                     end
                  end
               endcase
            end
            ST_ACK: begin
               sub_in = sub_ff + 3'd1;
               unique case (sub_ff)
                  AckClkLow:  clk_in = 1'b0;
                  AckRelease: dat_in = 1'b1;
                  AckClkHigh: clk_in = 1'b1;
                  AckClkDrop: clk_in = 1'b0;
                  default: begin
                     dat_in = 1'b0;
                     bit_in = '0;
                     if (last_byte) begin
                        state_in = ST_STOP;
                        sub_in   = EdgeFirst;
                     end else begin
                        state_in = ST_BITS;
                        sub_in   = BitClkLow;
                        byte_in  = byte_ff + ByteW'(1);
                     end
                  end
               endcase
            end
            default: begin
               unique case (sub_ff)
                  EdgeFirst:  clk_in = 1'b0;
                  EdgeSecond: dat_in = 1'b0;
                  EdgeThird:  clk_in = 1'b1;
                  default:    dat_in = 1'b1;
               endcase
               sub_in = sub_ff + 3'd1;
               if (sub_ff == EdgeLast) begin
                  sub_in  = EdgeFirst;
                  byte_in = '0;
                  if (frame_ff == FrameCtrl) begin
                     state_in = ST_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     state_in = ST_START;
                     frame_in = frame_ff + 2'd1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sub_ff    <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         frame_ff  <= FrameData;
         shift_ff  <= '0;
         clk_ff    <= 1'b1;
         dat_ff    <= 1'b1;
         bright_ff <= BrightReset;
      end else begin
         state_ff  <= state_in;
         sub_ff    <= sub_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         frame_ff  <= frame_in;
         shift_ff  <= shift_in;
         clk_ff    <= clk_in;
         dat_ff    <= dat_in;
         bright_ff <= bright_in;
         seg_ff    <= seg_in;
      end
   end

   assign result.clock_line = clk_in;
   assign result.data_line  = dat_in;
   assign result.busy_res   = (state_in != ST_IDLE);
   assign result.done_res   = done_in;

endmodule

// ----- hdl/seven_segment_two_wire_writer.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Two-wire seven-segment display writer
// Sends data command, address plus segment bytes and display control frames.
// -----------------------------------------------------------------------------
// Each request beat is either a tick (mode 0), which performs exactly one pin
// write of a running sequence, or an update (mode 1), which latches the
// segment bytes and starts the sequence when the writer is idle and is
// ignored otherwise. Every request beat yields exactly one response beat with
// the clock and data line levels after that beat, a busy flag and a done flag
// that marks the final stop write. The writer takes one request beat per
// clock cycle and returns its response in the next cycle; the response
// register is the only stage, and a new beat is taken while a response waits
// as long as that response is taken in the same cycle. A full update takes
// 2*37 + 8 + 29*(DIGITS+1) tick beats, which is 227 ticks for four digits, as
// counted by the state, bit, byte and frame counters of the sequencer.
// Brightness is sampled when the control byte is loaded.
// -----------------------------------------------------------------------------
module seven_segment_two_wire_writer
   import sws_pkg::*;
#(
   parameter int DIGITS = DigitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [BrightW-1:0] csr_write_data,
   sws_req_if.sink            req_chan,
   sws_rsp_if.source          rsp_chan
);

   logic        rsp_valid_ff, rsp_valid_in;
   seq_out_type rsp_data_ff,  rsp_data_in;
   seq_out_type seq_result;
   seg_vec_type req_segments;
   logic        req_accept;

   // The response register frees up when it is empty or drained this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign req_segments = {req_chan.segment_3, req_chan.segment_2,
                          req_chan.segment_1, req_chan.segment_0};

   sws_seq #(
      .DIGITS (DIGITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .mode             (req_chan.mode),
      .segments         (req_segments),
      .result           (seq_result)
   );

   // A response beat is loaded on every accepted request and held until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.clock_line = rsp_data_ff.clock_line;
   assign rsp_chan.data_line  = rsp_data_ff.data_line;
   assign rsp_chan.busy_res   = rsp_data_ff.busy_res;
   assign rsp_chan.done_res   = rsp_data_ff.done_res;

`ifndef SYNTHESIS
   // The final stop write ends the sequence, so done never comes with busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done reported while still busy");

   // The final stop write leaves both lines released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> rsp_chan.clock_line && rsp_chan.data_line)
      else $error("sequence finished with a line held low");

   // A stalled response beat must block new request beats.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while response stalled");

   // An accepted request beat always produces a response beat next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> rsp_chan.valid)
      else $error("accepted request produced no response");
`endif

endmodule

// ----- sim/seven_segment_two_wire_writer_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Seven-segment two-wire writer testbench
// Drives tick and update beats with random gaps and stalls. Predicts every
// clock and data line level of the three-frame update sequence, checks each
// response beat field by field, and changes the brightness between updates.
// -----------------------------------------------------------------------------
module seven_segment_two_wire_writer_tb;
   import sws_pkg::*;

   // Request codes carried in the mode field.
   localparam logic ModeTick   = 1'b0;
   localparam logic ModeUpdate = 1'b1;

   // Shape of the write sequence: every bit costs three writes, the ACK clock
   // five, and each frame is wrapped in a four-write start and stop.
   localparam int NumDigits  = DigitsDefault;
   localparam int ByteWrites = 29;
   localparam int EdgeWrites = 4;
   localparam int ShortFrame = EdgeWrites * 2 + ByteWrites;
   localparam int LongFrame  = EdgeWrites * 2 + ByteWrites * (1 + NumDigits);
   localparam int AllWrites  = ShortFrame * 2 + LongFrame;

   // Beats with an effect on the writer that the random part aims for.
   localparam int BeatTarget = 650;

   // Tracks the line levels the writer should report and checks each response
   // beat against the oldest one still waiting.
   class line_level_tracker;
      logic [BrightW-1:0] brightness;
      int                 write_index;
      logic [2:0]         bit_pos;
      logic [SegW-1:0]    shifter;
      seg_vec_type        segments;
      logic               clk_lvl;
      logic               dat_lvl;
      logic               running;
      seq_out_type        expected_levels[$];
      int failures, checked, updates, finished, ignored, idle_ticks, effective;

      function new();
         brightness  = BrightReset;
         write_index = 0;
         bit_pos     = '0;
         shifter     = '0;
         segments    = '0;
         clk_lvl     = 1'b1;
         dat_lvl     = 1'b1;
         running     = 1'b0;
         failures    = 0;
         checked     = 0;
         updates     = 0;
         finished    = 0;
         ignored     = 0;
         idle_ticks  = 0;
         effective   = 0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // Byte k of the given frame; brightness is taken when the byte loads.
      function logic [SegW-1:0] frame_byte(logic [1:0] frame, int k);
         if (frame == FrameData) return CmdData;
         if (frame == FrameCtrl) return CmdDisplay | {{(SegW-BrightW){1'b0}}, brightness};
         if (k == 0) return CmdAddr;
         return segments[k-1];
      endfunction

      // The one pin write at the current position of the sequence.
      function void pin_write();
         int s, o, len, r, k, b;
         logic [1:0] frame;
         s = write_index;
         if (s < ShortFrame) begin
            frame = FrameData; len = ShortFrame; o = s;
         end else if (s < ShortFrame + LongFrame) begin
            frame = FrameAddr; len = LongFrame; o = s - ShortFrame;
         end else begin
            frame = FrameCtrl; len = ShortFrame; o = s - ShortFrame - LongFrame;
         end
         if (o < EdgeWrites) begin
            // Start condition: data high, clock high, data low, clock low.
            case (o)
               0: dat_lvl = 1'b1;
               1: clk_lvl = 1'b1;
               2: dat_lvl = 1'b0;
               default: clk_lvl = 1'b0;
            endcase
         end else if (o >= len - EdgeWrites) begin
            // Stop condition: clock low, data low, clock high, data high.
            case (o - (len - EdgeWrites))
               0: clk_lvl = 1'b0;
               1: dat_lvl = 1'b0;
               2: clk_lvl = 1'b1;
               default: dat_lvl = 1'b1;
            endcase
         end else begin
            r = o - EdgeWrites;
            k = r / ByteWrites;
            b = r % ByteWrites;
            if (b < 24) begin
               bit_pos = 3'((b / 3) % 8);
               case (b % 3)
                  0: begin
                     if (bit_pos == 3'd0) shifter = frame_byte(frame, k);
                     clk_lvl = 1'b0;
                  end
                  1: begin
                     dat_lvl = shifter[0];
                     shifter = shifter >> 1;
                  end
                  default: clk_lvl = 1'b1;
               endcase
            end else begin
               // ACK clock with the data line released, then pulled low.
               case (b - 24)
                  0: clk_lvl = 1'b0;
                  1: dat_lvl = 1'b1;
                  2: clk_lvl = 1'b1;
                  3: clk_lvl = 1'b0;
                  default: dat_lvl = 1'b0;
               endcase
            end
         end
      endfunction

      // Advances the state by one accepted request beat.
      function void note_request(logic beat_mode, seg_vec_type beat_segs);
         seq_out_type want;
         logic done;
         done = 1'b0;
         if (beat_mode == ModeUpdate) begin
            if (!running) begin
               segments    = beat_segs;
               write_index = 0;
               bit_pos     = '0;
               running     = 1'b1;
               updates++;
               effective++;
            end else begin
               ignored++;
            end
         end else if (running) begin
            pin_write();
            write_index++;
            effective++;
            if (write_index >= AllWrites) begin
               write_index = 0;
               bit_pos     = '0;
               running     = 1'b0;
               done        = 1'b1;
               finished++;
            end
         end else begin
            idle_ticks++;
         end
         want.clock_line = clk_lvl;
         want.data_line  = dat_lvl;
         want.busy_res   = running;
         want.done_res   = done;
         expected_levels.push_back(want);
      endfunction

      function void compare_bit(string field, logic want, logic seen);
         if (seen !== want) begin
            $error("%s: expected %0b, got %0b", field, want, seen);
            failures++;
         end
      endfunction

      function void check_levels(seq_out_type seen);
         seq_out_type want;
         if (expected_levels.size() == 0) begin
            $error("response beat arrived with no expectation waiting");
            failures++;
            return;
         end
         want = expected_levels.pop_front();
         checked++;
         compare_bit("clock_line", want.clock_line, seen.clock_line);
         compare_bit("data_line", want.data_line, seen.data_line);
         compare_bit("busy_res", want.busy_res, seen.busy_res);
         compare_bit("done_res", want.done_res, seen.done_res);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [BrightW-1:0] csr_write_data;

   sws_req_if req_if ();
   sws_rsp_if rsp_if ();

   seven_segment_two_wire_writer #(
      .DIGITS (NumDigits)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   line_level_tracker tracker;

   // Random idling state of both sides; a calm count holds off idling for a
   // stretch so that long runs of back-to-back beats also occur.
   int req_calm;
   int rsp_stall;
   int rsp_calm;
   int settings_used;

   // 4 ns clock period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Mostly no gap, often a short one, rarely a long one.
   function int pick_gap();
      int roll;
      if (req_calm > 0) begin
         req_calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 93) return $urandom_range(4, 10);
      if (roll < 95) return $urandom_range(20, 40);
      req_calm = $urandom_range(20, 80);
      return 0;
   endfunction

   // The response side stalls in the same spirit. A stall is counted down one
   // cycle at a time, so it can begin on any phase of the sequence.
   always @(posedge clock) begin
      int roll;
      if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15) rsp_stall = $urandom_range(1, 3);
            else if (roll < 18) rsp_stall = $urandom_range(4, 12);
            else if (roll < 19) rsp_stall = $urandom_range(20, 40);
            else if (roll < 21) rsp_calm = $urandom_range(20, 80);
         end
      end
   end

   // Every accepted response beat is checked against the oldest expectation.
   // Expectations are pushed by the request driver at acceptance; the response
   // register sits behind the request side, so push and pop never race for one beat.
   always @(posedge clock) begin
      seq_out_type seen;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.clock_line = rsp_if.clock_line;
         seen.data_line  = rsp_if.data_line;
         seen.busy_res   = rsp_if.busy_res;
         seen.done_res   = rsp_if.done_res;
         tracker.check_levels(seen);
      end
   end

   // Presents one request beat and returns at the edge where it is taken.
   // Valid is only lowered when a gap follows, so a beat that follows directly
   // keeps valid high without a second assignment in the same step.
   task automatic send_beat(input logic beat_mode, input seg_vec_type beat_segs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.mode      <= beat_mode;
      req_if.segment_0 <= beat_segs[0];
      req_if.segment_1 <= beat_segs[1];
      req_if.segment_2 <= beat_segs[2];
      req_if.segment_3 <= beat_segs[3];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_request(beat_mode, beat_segs);
   endtask

   // Stops sending and waits until every response beat has come back.
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_brightness(input logic [BrightW-1:0] level);
      csr_write_enable <= 1'b1;
      csr_write_data   <= level;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.brightness = level;
      settings_used++;
   endtask

   // Brightness for the update that follows the given number of finished ones.
   function logic [BrightW-1:0] brightness_for(int finished);
      case (finished)
         1: return 3'd7;
         2: return 3'($urandom_range(1, 6));
         3: return 3'd0;
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      seg_vec_type segs;
      int          settled;
      tracker = new();
      req_calm         = 0;
      rsp_stall        = 0;
      rsp_calm         = 0;
      settings_used    = 0;
      settled          = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.mode      <= ModeTick;
      req_if.segment_0 <= '0;
      req_if.segment_1 <= '0;
      req_if.segment_2 <= '0;
      req_if.segment_3 <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_brightness(3'd3);

      // Directed part. Ticks while idle must not touch the lines, whatever
      // their payload holds.
      send_beat(ModeTick, '1);
      send_beat(ModeTick, '0);
      // Update with extreme and alternating segment patterns.
      send_beat(ModeUpdate, {8'h5A, 8'hA5, 8'h00, 8'hFF});
      // An update while busy must be ignored and must not replace the
      // latched segments.
      send_beat(ModeUpdate, {8'h78, 8'h56, 8'h34, 8'h12});
      repeat (10) send_beat(ModeTick, $urandom);
      send_beat(ModeUpdate, '1);
      // Brightness changed in the middle of a sequence, long before the
      // control byte loads, must show up in that control byte.
      drain_responses();
      write_brightness(3'd0);
      repeat (10) send_beat(ModeTick, $urandom);

      // Random part: mostly complete update sequences with random segments,
      // some updates thrown in while busy, and a few ticks while idle.
      while (tracker.effective < BeatTarget || tracker.running) begin
         if (tracker.running) begin
            if ($urandom_range(0, 99) < 3) send_beat(ModeUpdate, $urandom);
            else send_beat(ModeTick, $urandom);
         end else begin
            if (tracker.finished != settled) begin
               settled = tracker.finished;
               drain_responses();
               write_brightness(brightness_for(settled));
            end
            segs = $urandom;
            if ($urandom_range(0, 99) < 25) send_beat(ModeTick, segs);
            else send_beat(ModeUpdate, segs);
         end
      end

      drain_responses();
      // Keep the clock running so that any stray response beat is caught.
      repeat (8) @(posedge clock);

      $display("Checked %0d response beats: %0d updates run to the end, %0d ignored while busy.",
               tracker.checked, tracker.finished, tracker.ignored);
      $display("Idle ticks: %0d, brightness settings written: %0d.",
               tracker.idle_ticks, settings_used);
      if (tracker.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Safety net in case the writer stops taking or returning beats.
   initial begin
      #4000000;
      $display("Timeout with %0d response beats still expected.", tracker.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
